// File: design/sacache_pkg.sv
// Shared types and constants for the set-associative cache tag-store model.
// Used by the channel interfaces and by the top level; depends on nothing.
`default_nettype none

package sacache_pkg;

	// Payload widths of the channels.
	localparam int ADDR_W     = 32;
	localparam int WAY_W      = 2;
	localparam int CNT_W      = 32;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 2;

	// Recency age of one line; zero is most recently used.
	localparam int AGE_W = 2;
	localparam logic [AGE_W-1:0] AGE_OLDEST = 2'd3;

	// Victim LFSR, Galois form.
	localparam int LFSR_W = 16;
	localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
	localparam logic [LFSR_W-1:0] LFSR_SEED = 16'h0001;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS_LOG2 = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POLICY    = 4'd1;

	// Replacement policy codes.
	localparam logic POLICY_LRU    = 1'b0;
	localparam logic POLICY_RANDOM = 1'b1;

	// Largest n with 2**n not above the argument (elaboration only).
	function automatic int floor_log2(input int value);
		int n;
		n = 0;
		while ((2 ** (n + 1)) <= value) begin
			n = n + 1;
		end
		return n;
	endfunction

endpackage

`default_nettype wire

// File: design/sacache_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on sacache_pkg for the field widths.
`default_nettype none

interface sacache_cfg_if import sacache_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: design/sacache_req_if.sv
// Lookup request channel: one byte address per transfer.
// Depends on sacache_pkg for the address width.
`default_nettype none

interface sacache_req_if import sacache_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] address;

	modport source (output valid, output address, input ready);
	modport sink   (input valid, input address, output ready);
endinterface

`default_nettype wire

// File: design/sacache_rsp_if.sv
// Lookup result channel: hit flag, way used and the running hit and miss counts.
// Depends on sacache_pkg for the field widths.
`default_nettype none

interface sacache_rsp_if import sacache_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             hit;
	logic [WAY_W-1:0] way_used;
	logic [CNT_W-1:0] hit_count;
	logic [CNT_W-1:0] miss_count;

	modport source (output valid, output hit, output way_used, output hit_count,
		output miss_count, input ready);
	modport sink   (input valid, input hit, input way_used, input hit_count,
		input miss_count, output ready);
endinterface

`default_nettype wire

// File: design/sacache_ram.sv
// Generic single-clock RAM: one write port, one read port with registered read data.
// Stands alone; no package needed.
`default_nettype none

module sacache_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; the data register holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: design/set_assoc_cache_hit_miss_model.sv
// Tag store of a set-associative cache that classifies each address as hit or miss.
// Depends on sacache_pkg, the three channel interfaces and sacache_ram.
`default_nettype none

// One lookup is accepted per cycle while the lookup stage can move on. Its
// result passes the lookup stage, then the output register, which holds the
// lookup stage while full and not emptied. The set's row is read from the line RAM
// at the request's transfer, then compared, updated and written back. Each RAM
// row holds every line that one set can use, so the whole set moves in one
// access; a lookup that follows directly on the same row takes the row being
// written back instead of the stale RAM data. After reset the block clears the
// RAM one row per cycle (CAPACITY_BYTES / BLOCK_BYTES / MAX_WAYS rows, 256 at the
// defaults) and holds req.ready low meanwhile; configuration writes are taken
// at all times but must only be made while no lookup is in flight.
module set_assoc_cache_hit_miss_model import sacache_pkg::*; #(
	parameter int CAPACITY_BYTES = 4096,
	parameter int BLOCK_BYTES    = 4,
	parameter int MAX_WAYS       = 4,
	parameter int ADDRESS_BITS   = 32
) (
	input wire logic    clk,
	input wire logic    arst_n,
	sacache_cfg_if.sink cfg,
	sacache_req_if.sink req,
	sacache_rsp_if.source rsp
);

	// Geometry derived from the parameters.
	localparam int LINES     = CAPACITY_BYTES / BLOCK_BYTES;
	localparam int LINE_LOG2 = floor_log2(LINES);
	localparam int LINE_W    = (LINE_LOG2 > 0) ? LINE_LOG2 : 1;
	localparam int BLK_LOG2  = floor_log2(BLOCK_BYTES);
	localparam int WAY_CAP   = (MAX_WAYS < LINES) ? MAX_WAYS : LINES;
	localparam int MAXWL     = floor_log2(WAY_CAP);
	localparam int NW        = 2 ** MAXWL;
	localparam int SLOT_W    = (MAXWL > 0) ? MAXWL : 1;
	localparam int ROW_LOG2  = LINE_LOG2 - MAXWL;
	localparam int ROWS      = 2 ** ROW_LOG2;
	localparam int ROW_W     = (ROW_LOG2 > 0) ? ROW_LOG2 : 1;
	localparam int A_W       = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
	localparam int BLK_W     = A_W - BLK_LOG2;
	localparam int EXT_W     = BLK_W + LINE_W;
	localparam int TAG_RAW   = BLK_W - LINE_LOG2 + MAXWL;
	localparam int TAG_W     = (TAG_RAW > 0) ? TAG_RAW : 1;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic             valid;
		logic [AGE_W-1:0] age;
	} entry_t;

	typedef entry_t [NW-1:0] row_t;

	// Configuration registers.
	logic [1:0] ways_log2_q;
	logic       policy_q;
	logic [1:0] wl_eff;

	// Clearing pass.
	logic             clr_busy_q;
	logic [ROW_W-1:0] clr_row_q;

	// Request decode.
	logic [BLK_W-1:0]  block_in;
	logic [EXT_W-1:0]  block_ext;
	logic [LINE_W-1:0] line_base;
	logic [ROW_W-1:0]  row_in;
	logic [SLOT_W-1:0] slot_in;
	logic [TAG_W-1:0]  tag_in;
	logic [4:0]        tag_shift;
	logic              accept;

	// Lookup stage.
	logic              valid_s1;
	logic              fwd_s1;
	logic [TAG_W-1:0]  tag_s1;
	logic [ROW_W-1:0]  row_s1;
	logic [SLOT_W-1:0] slot_s1;
	row_t              fwd_row_q;
	logic              s1_adv;
	logic              done;

	// Lookup datapath.
	row_t              row_cur;
	row_t              row_new;
	logic [SLOT_W-1:0] waymask;
	logic [NW-1:0]     in_set;
	logic              hit;
	logic [SLOT_W-1:0] hit_slot;
	logic              inv_found;
	logic [SLOT_W-1:0] inv_slot;
	logic [AGE_W-1:0]  best_age;
	logic [SLOT_W-1:0] lru_slot;
	logic [SLOT_W-1:0] used_slot;
	logic [AGE_W-1:0]  old_age;
	logic [WAY_W-1:0]  way_full;
	logic [LFSR_W-1:0] lfsr_q;
	logic [LFSR_W-1:0] lfsr_next;

	// Counters.
	logic [CNT_W-1:0] hits_q;
	logic [CNT_W-1:0] misses_q;
	logic [CNT_W-1:0] hits_next;
	logic [CNT_W-1:0] misses_next;

	// Output register.
	logic             out_valid_q;
	logic             out_hit_q;
	logic [WAY_W-1:0] out_way_q;
	logic [CNT_W-1:0] out_hits_q;
	logic [CNT_W-1:0] out_misses_q;

	// RAM ports.
	logic                     ram_we;
	logic [ROW_W-1:0]         ram_waddr;
	logic [$bits(row_t)-1:0]  ram_wdata;
	logic [$bits(row_t)-1:0]  ram_rdata;

	// Configuration writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ways_log2_q <= 2'd0;
			policy_q    <= POLICY_LRU;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_WAYS_LOG2: ways_log2_q <= cfg.data[1:0];
				CFG_POLICY:    policy_q    <= cfg.data[0];
				default:       ;
			endcase
		end
	end

	// Associativity in use: the request is halved until it fits the row.
	assign wl_eff  = (ways_log2_q > 2'(MAXWL)) ? 2'(MAXWL) : ways_log2_q;
	assign waymask = SLOT_W'((1 << wl_eff) - 1);

	// Clearing pass after reset, one row per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_row_q  <= '0;
		end else if (clr_busy_q) begin
			clr_row_q <= clr_row_q + 1'b1;
			if (clr_row_q == ROW_W'(ROWS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Split the address into line position and tag under the current associativity.
	assign block_in  = BLK_W'(req.address[A_W-1:0] >> BLK_LOG2);
	assign block_ext = EXT_W'(block_in);
	assign line_base = LINE_W'((block_ext << wl_eff) & EXT_W'(LINES - 1));
	assign row_in    = ROW_W'(line_base >> MAXWL);
	assign slot_in   = SLOT_W'(line_base & LINE_W'(NW - 1));
	assign tag_shift = 5'(LINE_LOG2) - 5'(wl_eff);
	assign tag_in    = TAG_W'(block_in >> tag_shift);

	// The lookup stage moves on when the output register is free or being emptied.
	assign s1_adv    = !out_valid_q || rsp.ready;
	assign done      = valid_s1 && s1_adv;
	assign req.ready = !clr_busy_q && (!valid_s1 || s1_adv);
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			fwd_s1   <= done && (row_in == row_s1);
		end else if (done) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end
	end

	// Lookup payload and the forwarded row for a back-to-back access to one row.
	always_ff @(posedge clk) begin
		if (accept) begin
			tag_s1    <= tag_in;
			row_s1    <= row_in;
			slot_s1   <= slot_in;
			fwd_row_q <= row_new;
		end
	end

	// Galois LFSR step used for a random victim.
	assign lfsr_next = {1'b0, lfsr_q[LFSR_W-1:1]} ^ (lfsr_q[0] ? LFSR_TAPS : '0);

	// Compare, victim choice and age update on the row of the set.
	always_comb begin
		row_cur   = fwd_s1 ? fwd_row_q : row_t'(ram_rdata);
		hit       = 1'b0;
		hit_slot  = slot_s1;
		inv_found = 1'b0;
		inv_slot  = slot_s1;
		best_age  = '0;
		lru_slot  = slot_s1;
		for (int k = 0; k < NW; k++) begin
			in_set[k] = (SLOT_W'(k) & ~waymask) == slot_s1;
			if (in_set[k] && !hit && row_cur[k].valid && row_cur[k].tag == tag_s1) begin
				hit      = 1'b1;
				hit_slot = SLOT_W'(k);
			end
			if (in_set[k] && !inv_found && !row_cur[k].valid) begin
				inv_found = 1'b1;
				inv_slot  = SLOT_W'(k);
			end
			if (in_set[k] && row_cur[k].age > best_age) begin
				best_age = row_cur[k].age;
				lru_slot = SLOT_W'(k);
			end
		end

		if (hit) begin
			used_slot = hit_slot;
		end else if (policy_q == POLICY_RANDOM) begin
			used_slot = slot_s1 | (SLOT_W'(lfsr_next) & waymask);
		end else if (inv_found) begin
			used_slot = inv_slot;
		end else begin
			used_slot = lru_slot;
		end

		// A line that is being filled counts as the oldest.
		old_age = row_cur[used_slot].valid ? row_cur[used_slot].age : AGE_OLDEST;

		row_new = row_cur;
		for (int k = 0; k < NW; k++) begin
			if (in_set[k] && SLOT_W'(k) != used_slot && row_cur[k].valid
					&& row_cur[k].age < old_age) begin
				row_new[k].age = row_cur[k].age + 1'b1;
			end
		end
		row_new[used_slot].age = '0;
		if (!hit) begin
			row_new[used_slot].valid = 1'b1;
			row_new[used_slot].tag   = tag_s1;
		end

		way_full = WAY_W'(used_slot & waymask);
	end

	// Saturating counters.
	assign hits_next   = (hit && hits_q != '1) ? hits_q + 1'b1 : hits_q;
	assign misses_next = (!hit && misses_q != '1) ? misses_q + 1'b1 : misses_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q   <= '0;
			misses_q <= '0;
			lfsr_q   <= LFSR_SEED;
		end else if (done) begin
			hits_q   <= hits_next;
			misses_q <= misses_next;
			if (!hit && policy_q == POLICY_RANDOM) begin
				lfsr_q <= lfsr_next;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_hit_q    <= hit;
			out_way_q    <= way_full;
			out_hits_q   <= hits_next;
			out_misses_q <= misses_next;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.hit        = out_hit_q;
	assign rsp.way_used   = out_way_q;
	assign rsp.hit_count  = out_hits_q;
	assign rsp.miss_count = out_misses_q;

	// Line RAM: clearing pass or write-back of the updated row.
	assign ram_we    = clr_busy_q || done;
	assign ram_waddr = clr_busy_q ? clr_row_q : row_s1;
	assign ram_wdata = clr_busy_q ? '0 : row_new;

	sacache_ram #(
		.WIDTH ($bits(row_t)),
		.DEPTH (ROWS)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (row_in),
		.rdata (ram_rdata)
	);

`ifndef NO_ASSERTIONS
	// No lookup may enter while the RAM is being cleared.
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !req.ready)
		else $error("lookup accepted during clearing pass");

	// The way chosen for a lookup lies inside its own set.
	a_used_in_set: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> in_set[used_slot])
		else $error("used line outside the addressed set");

	// Counters and LFSR move only when a lookup completes.
	a_state_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!done |=> $stable(hits_q) && $stable(misses_q) && $stable(lfsr_q))
		else $error("lookup state changed without a lookup");

	// The LFSR never locks up at zero.
	a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		lfsr_q != '0)
		else $error("LFSR reached zero");
`endif

endmodule

`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for the set-associative cache tag-store model.
// It keeps its own copy of the tag store and checks every lookup result.
// Depends on sacache_pkg, the three channel interfaces and the top level.
`timescale 1ns / 100ps

module tb;
	import sacache_pkg::*;

	localparam int CAPACITY_BYTES = 4096;
	localparam int BLOCK_BYTES    = 4;
	localparam int MAX_WAYS       = 4;
	localparam int ADDRESS_BITS   = 32;
	localparam int LINES          = CAPACITY_BYTES / BLOCK_BYTES;
	localparam int RUN_LIMIT_NS   = 400_000;
	localparam int PHASE_ITEMS    = 110;

	// One expected lookup result, with its address kept for the report.
	typedef struct {
		logic [ADDR_W-1:0] address;
		logic              hit;
		logic [WAY_W-1:0]  way_used;
		logic [CNT_W-1:0]  hit_count;
		logic [CNT_W-1:0]  miss_count;
	} lookup_result_t;

	logic clk;
	logic arst_n;

	sacache_cfg_if cfg_if ();
	sacache_req_if req_if ();
	sacache_rsp_if rsp_if ();

	set_assoc_cache_hit_miss_model #(
		.CAPACITY_BYTES(CAPACITY_BYTES),
		.BLOCK_BYTES   (BLOCK_BYTES),
		.MAX_WAYS      (MAX_WAYS),
		.ADDRESS_BITS  (ADDRESS_BITS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_if),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	// Local copy of the tag store, the recency ages and the counters.
	bit [31:0]        line_tag   [LINES];
	bit               line_valid [LINES];
	bit [AGE_W-1:0]   line_age   [LINES];
	bit [LFSR_W-1:0]  victim_lfsr = LFSR_SEED;
	bit [CNT_W-1:0]   hits_seen;
	bit [CNT_W-1:0]   misses_seen;
	bit [1:0]         sel_ways_log2;
	bit               sel_policy;

	lookup_result_t expected_lookups [$];
	int mismatch_count;
	int stall_hold;
	int burst_left;
	bit sender_gaps_on;

	// Clock with a 2 ns period.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard limit on the run time.
	initial begin
		#(RUN_LIMIT_NS);
		$display("FAIL set_assoc_cache_hit_miss_model");
		$finish;
	end

	// Associativity in use: an oversized request is halved until it fits.
	function automatic int active_ways();
		int w;
		w = 1 << sel_ways_log2;
		while (w > 1 && (w > MAX_WAYS || w > LINES)) begin
			w = w >> 1;
		end
		return w;
	endfunction

	// Classifies one address, updates the local tag store and returns the result.
	function automatic lookup_result_t predict_lookup(input logic [ADDR_W-1:0] address);
		lookup_result_t res;
		int ways;
		int sets;
		int base;
		int used;
		int w;
		logic [31:0] blk;
		logic [31:0] set_idx;
		logic [31:0] tag_val;
		logic [AGE_W-1:0] used_age;
		logic hit_found;
		logic lsb;
		ways = active_ways();
		sets = LINES / ways;
		blk = address / BLOCK_BYTES;
		set_idx = blk % sets;
		tag_val = blk / sets;
		base = set_idx * ways;
		hit_found = 1'b0;
		used = 0;
		for (w = 0; w < ways; w++) begin
			if (!hit_found && line_valid[base + w] && line_tag[base + w] == tag_val) begin
				hit_found = 1'b1;
				used = w;
			end
		end

		if (hit_found) begin
			if (hits_seen != '1)
				hits_seen++;
		end else begin
			if (misses_seen != '1)
				misses_seen++;
			if (sel_policy == POLICY_RANDOM) begin
				// Galois LFSR steps once per miss; its low bits pick the victim.
				lsb = victim_lfsr[0];
				victim_lfsr = victim_lfsr >> 1;
				if (lsb)
					victim_lfsr = victim_lfsr ^ LFSR_TAPS;
				used = int'(victim_lfsr) & (ways - 1);
			end else begin
				// Lowest invalid way first, else the lowest of the oldest ways.
				used = -1;
				for (w = 0; w < ways; w++) begin
					if (used < 0 && !line_valid[base + w])
						used = w;
				end
				if (used < 0) begin
					used = 0;
					for (w = 1; w < ways; w++) begin
						if (line_age[base + w] > line_age[base + used])
							used = w;
					end
				end
			end
		end

		// The used way becomes youngest; younger valid ways age by one.
		used_age = line_valid[base + used] ? line_age[base + used] : AGE_OLDEST;
		for (w = 0; w < ways; w++) begin
			if (w != used && line_valid[base + w] && line_age[base + w] < used_age)
				line_age[base + w] = line_age[base + w] + 1'b1;
		end
		line_age[base + used] = '0;
		if (!hit_found) begin
			line_tag[base + used] = tag_val;
			line_valid[base + used] = 1'b1;
		end

		res.address = address;
		res.hit = hit_found;
		res.way_used = used[WAY_W-1:0];
		res.hit_count = hits_seen;
		res.miss_count = misses_seen;
		return res;
	endfunction

	// Builds an address from a tag and a set under the geometry in use.
	function automatic logic [ADDR_W-1:0] compose_address(input logic [31:0] tag_val,
			input int set_idx, input int offset);
		logic [31:0] blk;
		blk = tag_val * (LINES / active_ways()) + set_idx;
		return blk * BLOCK_BYTES + offset;
	endfunction

	task automatic note_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%s", msg);
	endtask

	// Writes one configuration register and mirrors it locally on transfer.
	task automatic write_register(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_if.valid = 1'b1;
		cfg_if.index = index;
		cfg_if.data = value;
		do @(posedge clk); while (!cfg_if.ready);
		if (index == CFG_WAYS_LOG2)
			sel_ways_log2 = value;
		else if (index == CFG_POLICY)
			sel_policy = value[0];
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	task automatic set_geometry(input logic [1:0] ways_log2, input logic policy);
		write_register(CFG_WAYS_LOG2, ways_log2);
		write_register(CFG_POLICY, {1'b0, policy});
	endtask

	// Offers one address, in bursts with random gaps while gaps are on; predicts it on transfer.
	task automatic send_lookup(input logic [ADDR_W-1:0] address);
		@(negedge clk);
		if (sender_gaps_on && burst_left == 0) begin
			req_if.valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 16);
		end
		req_if.valid = 1'b1;
		req_if.address = address;
		do @(posedge clk); while (!req_if.ready);
		expected_lookups.push_back(predict_lookup(address));
		if (burst_left > 0)
			burst_left--;
	endtask

	// Stops offering and waits until every expected result has come back.
	task automatic drain_lookups();
		@(negedge clk);
		req_if.valid = 1'b0;
		while (expected_lookups.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Result checker: each transfer is compared with the oldest expectation.
	always @(posedge clk) begin
		lookup_result_t exp_res;
		if (rsp_if.valid === 1'b1 && rsp_if.ready) begin
			if (expected_lookups.size() == 0) begin
				note_mismatch($sformatf(
					"unexpected result: hit=%b way=%0d hits=%0d misses=%0d",
					rsp_if.hit, rsp_if.way_used, rsp_if.hit_count, rsp_if.miss_count));
			end else begin
				exp_res = expected_lookups.pop_front();
				if (rsp_if.hit !== exp_res.hit || rsp_if.way_used !== exp_res.way_used ||
						rsp_if.hit_count !== exp_res.hit_count ||
						rsp_if.miss_count !== exp_res.miss_count)
					note_mismatch($sformatf({
						"mismatch at %h: expected hit=%b way=%0d hits=%0d misses=%0d, ",
						"got hit=%b way=%0d hits=%0d misses=%0d"},
						exp_res.address, exp_res.hit, exp_res.way_used, exp_res.hit_count,
						exp_res.miss_count, rsp_if.hit, rsp_if.way_used, rsp_if.hit_count,
						rsp_if.miss_count));
			end
		end
	end

	// Result side: a held stall when requested, else a changing stall pattern.
	initial begin
		int mode;
		int mode_left;
		int tick;
		int pause_left;
		rsp_if.ready = 1'b0;
		mode = 0;
		mode_left = 0;
		tick = 0;
		pause_left = 0;
		forever begin
			@(negedge clk);
			if (stall_hold > 0) begin
				rsp_if.ready = 1'b0;
				stall_hold--;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 80);
				end
				mode_left--;
				tick++;
				case (mode)
					0: rsp_if.ready = 1'b1;
					1: rsp_if.ready = 1'($urandom_range(0, 1));
					2: rsp_if.ready = (tick % 4) != 3;
					default: begin
						if (pause_left > 0) begin
							rsp_if.ready = 1'b0;
							pause_left--;
						end else if ($urandom_range(0, 15) == 0) begin
							rsp_if.ready = 1'b0;
							pause_left = $urandom_range(3, 12);
						end else begin
							rsp_if.ready = 1'b1;
						end
					end
				endcase
			end
		end
	end

	// Direct mapped: address extremes, offsets within a block and a conflict.
	task automatic test_direct_mapped_extremes();
		set_geometry(2'd0, POLICY_LRU);
		send_lookup(32'h0000_0000);
		send_lookup(32'hFFFF_FFFF);
		send_lookup(32'h0000_0000);
		send_lookup(32'hFFFF_FFFF);
		send_lookup(32'h0000_0003);
		send_lookup(32'h0000_1000);
		send_lookup(32'h0000_0000);
		drain_lookups();
	endtask

	// Four ways: fill one set, evict the oldest, refresh, evict again.
	task automatic test_four_way_lru_eviction();
		set_geometry(2'd2, POLICY_LRU);
		send_lookup(32'h0000_0000);
		send_lookup(32'h0000_0400);
		send_lookup(32'h0000_0800);
		send_lookup(32'h0000_0C00);
		send_lookup(32'h0000_1000);
		send_lookup(32'h0000_0400);
		send_lookup(32'h0000_0000);
		drain_lookups();
	endtask

	// An associativity request above the maximum, with random replacement.
	task automatic test_oversized_associativity();
		set_geometry(2'd3, POLICY_RANDOM);
		send_lookup(32'h0000_0000);
		send_lookup(32'h0000_1000);
		send_lookup(32'h0000_2000);
		send_lookup(32'h0000_3000);
		send_lookup(32'h0000_0000);
		drain_lookups();
	endtask

	// Stored lines survive a change of geometry and are read under the new split.
	task automatic test_geometry_change_without_flush();
		set_geometry(2'd1, POLICY_LRU);
		send_lookup(32'h0000_0000);
		send_lookup(32'h0000_0800);
		drain_lookups();
		write_register(CFG_WAYS_LOG2, 2'd0);
		send_lookup(32'h0000_0000);
		send_lookup(32'h0000_0800);
		drain_lookups();
	endtask

	// Mostly a small working set on a few sets, so that hits and evictions
	// dominate, mixed with fully random addresses.
	task automatic run_traffic(input int count);
		logic [ADDR_W-1:0] pool [12];
		int hot_sets [3];
		int pool_len;
		int sets;
		int i;
		int pick;
		sets = LINES / active_ways();
		hot_sets[0] = 0;
		hot_sets[1] = sets - 1;
		hot_sets[2] = $urandom_range(1, sets - 2);
		pool_len = $urandom_range(5, 12);
		for (i = 0; i < pool_len; i++)
			pool[i] = compose_address($urandom, hot_sets[$urandom_range(0, 2)], 0);
		for (i = 0; i < count; i++) begin
			pick = $urandom_range(0, 19);
			if (pick < 15) begin
				send_lookup(pool[$urandom_range(0, pool_len - 1)] | $urandom_range(0, 3));
			end else if (pick < 16) begin
				pool[$urandom_range(0, pool_len - 1)] =
					compose_address($urandom, hot_sets[$urandom_range(0, 2)], 0);
				send_lookup(pool[0]);
			end else begin
				send_lookup($urandom);
			end
		end
		drain_lookups();
	endtask

	// Random traffic under every geometry and both replacement policies.
	task automatic test_random_traffic();
		logic [1:0] ways_order [8];
		logic       policy_order [8];
		int phase;
		ways_order   = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd1, 2'd0, 2'd3};
		policy_order = '{POLICY_LRU, POLICY_LRU, POLICY_LRU, POLICY_LRU,
			POLICY_RANDOM, POLICY_RANDOM, POLICY_RANDOM, POLICY_RANDOM};
		for (phase = 0; phase < 8; phase++) begin
			set_geometry(ways_order[phase], policy_order[phase]);
			sender_gaps_on = $urandom_range(0, 3) != 0;
			run_traffic(PHASE_ITEMS);
		end
	endtask

	// The result side holds off for a long stretch while addresses keep coming,
	// so the block fills up and stalls its input.
	task automatic test_backpressure();
		set_geometry(2'd2, POLICY_LRU);
		sender_gaps_on = 1'b0;
		stall_hold = 200;
		run_traffic(40);
		sender_gaps_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = CFG_WAYS_LOG2;
		cfg_if.data = '0;
		req_if.valid = 1'b0;
		req_if.address = '0;
		mismatch_count = 0;
		stall_hold = 0;
		burst_left = 0;
		sender_gaps_on = 1'b1;
		sel_ways_log2 = 2'd0;
		sel_policy = POLICY_LRU;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_direct_mapped_extremes();
		test_four_way_lru_eviction();
		test_oversized_associativity();
		test_geometry_change_without_flush();
		test_random_traffic();
		test_backpressure();

		drain_lookups();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && expected_lookups.size() == 0) begin
			$display("PASS set_assoc_cache_hit_miss_model");
		end else begin
			$display("FAIL set_assoc_cache_hit_miss_model");
		end
		$finish;
	end

endmodule

// File: files.f
design/sacache_pkg.sv
design/sacache_cfg_if.sv
design/sacache_req_if.sv
design/sacache_rsp_if.sv
design/sacache_ram.sv
design/set_assoc_cache_hit_miss_model.sv
dv/tb.sv
